### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the template bijection checker.
// No dependencies; the including module must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define TBC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define TBC_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define TBC_ASSERT(lbl, prop, msg)
`define TBC_NEVER(lbl, expr, msg)

`endif

`endif

### rtl/tbc_pkg.sv
// Constants and types for the template bijection checker.
// No dependencies; imported by template_bijection_checker.
package tbc_pkg;

    localparam int TEMPLATE_DEPTH = 4096;
    localparam int ADDR_W         = $clog2(TEMPLATE_DEPTH);
    localparam int POS_W          = ADDR_W + 1;   // holds 0..TEMPLATE_DEPTH
    localparam int ALPHABET_SIZE  = 26;
    localparam int LETTER_W       = 5;
    localparam int VALUE_W        = 32;
    localparam int S_TDATA_W      = 40;            // value + letter, padded to bytes
    localparam int M_TDATA_W      = 8;

    // tuser command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_CHECK = 1'b1;

    // operation carried to the map stage
    typedef enum logic {
        OP_CLEAR,
        OP_CHECK
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [LETTER_W-1:0] letter;
        logic                last;
        logic                in_range;   // position below template length and depth
        logic                len_ok;     // position + 1 equals template length
    } s1_t;

endpackage

### rtl/template_bijection_checker.sv
// Template bijection checker: template memory, letter map and stream handshake.
// Depends on tbc_pkg and assert_macros.svh.
//
// Usage:
//   Slave stream (s_*): one transfer per item. s_tuser = command (0 load template
//   element, 1 check candidate letter), s_tlast marks the last element or letter.
//   s_tdata[31:0] is the template value, s_tdata[36:32] the letter index (a=0).
//   A template is loaded element by element; each candidate follows letter by
//   letter and gets one verdict on the master stream at its last letter.
//   Master stream (m_*): m_tdata[0] = 1 when the candidate pairs one to one with
//   the template and has the same length, 0 otherwise.
// Timing: an item is accepted every cycle while s_tready is high. The template
//   memory is read at accept (synchronous read), the map stage checks and updates
//   the letter map, and the output register holds the verdict: a last letter
//   passes the map stage and output registers before m_tvalid rises. The 26-entry
//   map is compared in parallel and is updated before the next letter reaches it.
// Reset: template length, position, the letter map valid bits and the pipeline
//   are cleared; the template memory keeps its content and is undefined until
//   loaded. No clearing pass is needed.
// Backpressure: while a verdict waits for m_tready the block keeps accepting
//   items; s_tready drops only when the map stage holds a last letter that
//   cannot move on.
`include "assert_macros.svh"

module template_bijection_checker
    import tbc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] value, [36:32] letter, [39:37] zero
    input  logic                 s_tuser,   // [0] cmd
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [0] verdict, [7:1] zero
);

    // ---------------- input unpack ----------------
    logic                 accept;
    logic                 in_cmd;
    logic [VALUE_W-1:0]   in_value;
    logic [LETTER_W-1:0]  in_letter;

    assign accept    = s_tvalid && s_tready;
    assign in_cmd    = s_tuser;
    assign in_value  = s_tdata[VALUE_W-1:0];
    assign in_letter = s_tdata[VALUE_W +: LETTER_W];

    // ---------------- front-end state ----------------
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  tlen_reg, tlen_next;
    logic [POS_W-1:0]  pos_inc;
    logic [ADDR_W-1:0] addr;
    logic              in_depth;

    assign in_depth = pos_reg < POS_W'(TEMPLATE_DEPTH);
    assign pos_inc  = pos_reg + POS_W'(1);
    assign addr     = pos_reg[ADDR_W-1:0];

    // map stage
    logic  s1_valid_reg, s1_valid_next;
    s1_t   s1_reg, s1_next;

    // output register
    logic  out_valid_reg;
    logic  verdict_reg;

    // letter map
    logic [ALPHABET_SIZE-1:0] bound_reg;
    logic [VALUE_W-1:0]       letter_val_reg [ALPHABET_SIZE];
    logic                     mismatch_reg;

    // template memory
    logic [VALUE_W-1:0] tmpl_mem [TEMPLATE_DEPTH];
    logic [VALUE_W-1:0] rdata_reg;

    // ---------------- stage handshake ----------------
    logic produces;
    logic fire;

    assign produces = (s1_reg.op == OP_CHECK) && s1_reg.last;
    assign fire     = s1_valid_reg && (!produces || !out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || fire;

    // ---------------- accept-side bookkeeping ----------------
    always_comb
    begin
        pos_next      = pos_reg;
        tlen_next     = tlen_reg;
        s1_next       = s1_reg;
        s1_valid_next = s1_valid_reg && !fire;
        if (accept)
        begin
            s1_next.letter   = in_letter;
            s1_next.last     = s_tlast;
            s1_next.in_range = in_depth && (pos_reg < tlen_reg);
            s1_next.len_ok   = (pos_inc == tlen_reg);
            if (in_cmd == CMD_LOAD)
            begin
                s1_next.op    = OP_CLEAR;
                s1_valid_next = s_tlast;   // only a last element touches the map
                if (s_tlast)
                begin
                    tlen_next = in_depth ? pos_inc : POS_W'(TEMPLATE_DEPTH);
                    pos_next  = '0;
                end
                else if (in_depth)
                begin
                    pos_next = pos_inc;
                end
            end
            else
            begin
                s1_next.op    = OP_CHECK;
                s1_valid_next = 1'b1;
                if (s_tlast)
                    pos_next = '0;
                else if (in_depth)
                    pos_next = pos_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            tlen_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            tlen_reg     <= tlen_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
    end

    // ---------------- template memory ----------------
    // Writes land at accept; a letter accepted later reads the new value,
    // so no forwarding is needed.
    always_ff @(posedge clk)
    begin
        if (accept && (in_cmd == CMD_LOAD) && in_depth)
            tmpl_mem[addr] <= in_value;
        if (accept)
            rdata_reg <= tmpl_mem[addr];
    end

    // ---------------- letter map check ----------------
    logic [ALPHABET_SIZE-1:0] sel;
    logic [ALPHABET_SIZE-1:0] hit;
    logic                     any_hit;
    logic                     letter_ok;
    logic                     pair_ok;
    logic                     do_bind;
    logic                     mism_new;

    always_comb
    begin
        for (int j = 0; j < ALPHABET_SIZE; j++)
        begin
            sel[j] = (s1_reg.letter == LETTER_W'(j));
            hit[j] = bound_reg[j] && (letter_val_reg[j] == rdata_reg);
        end
        any_hit   = |hit;
        letter_ok = s1_reg.letter < LETTER_W'(ALPHABET_SIZE);
        // values are unique among bound letters, so at most one hit
        pair_ok   = any_hit ? |(hit & sel) : !(|(bound_reg & sel));
        do_bind   = !mismatch_reg && s1_reg.in_range && letter_ok && !any_hit && pair_ok;
        mism_new  = mismatch_reg || !s1_reg.in_range || !letter_ok || !pair_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_reg    <= '0;
            mismatch_reg <= 1'b0;
        end
        else if (fire)
        begin
            if ((s1_reg.op == OP_CLEAR) || s1_reg.last)
            begin
                bound_reg    <= '0;
                mismatch_reg <= 1'b0;
            end
            else
            begin
                mismatch_reg <= mism_new;
                if (do_bind)
                    bound_reg <= bound_reg | sel;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < ALPHABET_SIZE; j++)
        begin
            if (fire && (s1_reg.op == OP_CHECK) && !s1_reg.last && do_bind && sel[j])
                letter_val_reg[j] <= rdata_reg;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire && produces)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire && produces)
            verdict_reg <= !mism_new && s1_reg.len_ok;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-1){1'b0}}, verdict_reg};

    // ---------------- assertions ----------------
    `TBC_NEVER(a_pos_range, pos_reg > POS_W'(TEMPLATE_DEPTH), "position beyond template depth")
    `TBC_NEVER(a_tlen_range, tlen_reg > POS_W'(TEMPLATE_DEPTH), "template length beyond depth")
    `TBC_ASSERT(a_stall_cause, !s_tready |-> (s1_valid_reg && out_valid_reg && !m_tready), "input stalled without a waiting verdict")
    `TBC_ASSERT(a_map_cleared, (fire && produces) |=> (bound_reg == '0 && !mismatch_reg), "letter map not cleared after verdict")

endmodule

### dv/template_bijection_checker_chk.sv
// Scoreboard for the template bijection checker: mirrors the template store and letter map.
// Watches both stream channels, predicts each verdict and compares it on the result side.
// Depends on tbc_pkg; instantiated beside the DUT by template_bijection_checker_tb.
module template_bijection_checker_chk
    import tbc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] value, [36:32] letter, [39:37] zero
    input  logic                 s_tuser,   // [0] cmd
    input  logic                 s_tlast,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,   // [0] verdict, [7:1] zero
    output int                   errors,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [POS_W-1:0] DEPTH_POS = POS_W'(TEMPLATE_DEPTH);

    // mirrored block state
    logic [VALUE_W-1:0]       tmpl_mem [TEMPLATE_DEPTH];
    logic [POS_W-1:0]         tmpl_len;
    logic [POS_W-1:0]         pos;
    logic [VALUE_W-1:0]       bound_val [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] bound;
    logic                     failed;

    logic                     verdict_q [$];
    int                       fail_cnt = 0;
    int                       wait_cnt = 0;

    assign errors  = fail_cnt;
    assign pending = wait_cnt;

    task automatic clear_map();
        pos    = '0;
        bound  = '0;
        failed = 1'b0;
    endtask

    task automatic step_pos();
        if (pos < DEPTH_POS)
            pos = pos + 1'b1;
    endtask

    // True when letter ltr may pair with v; binds the pair on first use.
    function automatic logic pair_fits(input logic [LETTER_W-1:0] ltr,
                                       input logic [VALUE_W-1:0]  v);
        for (int j = 0; j < ALPHABET_SIZE; j++)
        begin
            if (bound[j] && bound_val[j] == v)
                return j == ltr;
        end
        if (bound[ltr])
            return 1'b0;
        bound[ltr]     = 1'b1;
        bound_val[ltr] = v;
        return 1'b1;
    endfunction

    task automatic take_item(input logic                cmd,
                             input logic [VALUE_W-1:0]  v,
                             input logic [LETTER_W-1:0] ltr,
                             input logic                lst);
        if (cmd == CMD_LOAD)
        begin
            if (pos < DEPTH_POS)
                tmpl_mem[pos[ADDR_W-1:0]] = v;
            if (lst)
            begin
                tmpl_len = (pos < DEPTH_POS) ? pos + 1'b1 : DEPTH_POS;
                clear_map();
            end
            else
                step_pos();
        end
        else
        begin
            if (pos >= tmpl_len || pos >= DEPTH_POS)
                failed = 1'b1;
            else if (!failed)
            begin
                // out-of-alphabet letters fail and bind nothing (short-circuit)
                if (ltr >= ALPHABET_SIZE || !pair_fits(ltr, tmpl_mem[pos[ADDR_W-1:0]]))
                    failed = 1'b1;
            end
            if (!lst)
                step_pos();
            else
            begin
                verdict_q.push_back(!failed && (pos + 1'b1 == tmpl_len));
                clear_map();
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic want;
        if (!rst_n)
        begin
            tmpl_len = '0;
            clear_map();
            verdict_q.delete();
            wait_cnt = 0;
        end
        else
        begin
            // result side first: a verdict leaving now belongs to an older letter
            if (m_tvalid && m_tready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $error("verdict: transfer with nothing expected, actual %0b", m_tdata[0]);
                    fail_cnt++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (m_tdata[0] !== want)
                    begin
                        $error("verdict: expected %0b, actual %0b", want, m_tdata[0]);
                        fail_cnt++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                take_item(s_tuser, s_tdata[VALUE_W-1:0],
                          s_tdata[VALUE_W +: LETTER_W], s_tlast);
            wait_cnt = verdict_q.size();
        end
    end

endmodule

### dv/template_bijection_checker_tb.sv
// Top-level testbench for template_bijection_checker: clock, reset, stimulus and verdict.
// Depends on tbc_pkg, the DUT and template_bijection_checker_chk (prediction and compare).
module template_bijection_checker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tbc_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 5;
    localparam int RANDOM_ITEMS = 600;
    localparam int PREFILL_LEN  = 64;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int TAIL_CYCLES  = 16;     // verdict passes the map stage and output registers after the last letter

    localparam logic [VALUE_W-1:0] V_MIN = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] V_MAX = 32'h7fff_ffff;

    localparam logic [LETTER_W-1:0] LTR_A   = 5'd0;
    localparam logic [LETTER_W-1:0] LTR_B   = 5'd1;
    localparam logic [LETTER_W-1:0] LTR_Y   = 5'd24;
    localparam logic [LETTER_W-1:0] LTR_Z   = 5'd25;
    localparam logic [LETTER_W-1:0] LTR_OUT = 5'd31;   // beyond the alphabet

    // receiver stall patterns
    typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_t;

    // candidate shapes for the random part
    typedef enum int {WK_MATCH, WK_TYPO, WK_SHORT, WK_LONG, WK_SCRAMBLE, WK_NOISE} word_kind_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;        // [31:0] value, [36:32] letter, [39:37] zero
    logic                 s_tuser  = CMD_LOAD;  // [0] cmd
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;              // [0] verdict, [7:1] zero

    int errors;
    int pending;

    int       cycle_cnt  = 0;
    int       sent_cnt   = 0;   // accepted input transfers so far
    int       burst_left = 0;   // transfers left in the current sender burst
    rx_mode_t rx_mode    = RX_OPEN;
    int       rx_left    = 0;
    int       rx_tick    = 0;

    // stimulus scratch: template being loaded and candidate being sent
    logic [VALUE_W-1:0]  tmpl_q [$];
    logic [LETTER_W-1:0] word_q [$];
    logic [VALUE_W-1:0]  pool_q [$];
    logic [VALUE_W-1:0]  alpha_vals [ALPHABET_SIZE];
    logic [VALUE_W-1:0]  corner_vals [4] = '{V_MIN, V_MAX, 32'h0, 32'hffff_ffff};

    template_bijection_checker i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    template_bijection_checker_chk i_chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (errors),
        .pending  (pending)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Watchdog: sized from the slowest legal run, with plenty of margin.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result-side backpressure. The pattern changes at random intervals so
    // that stalls hit verdicts at every pipeline phase; RX_OPEN gives stretches
    // with no stall at all.
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_OPEN:     m_tready <= 1'b1;
            RX_COIN:     m_tready <= $urandom_range(0, 1);
            RX_PERIODIC: m_tready <= (rx_tick % 4) == 3;
            default:     m_tready <= $urandom_range(0, 7) != 0;
        endcase
    end

    // One input transfer. Drives at the falling edge, then holds until the
    // block takes it. Bursts of random length are separated by random gaps;
    // inside a burst tvalid stays high from one transfer to the next.
    task automatic put_item(input logic                cmd,
                            input logic [VALUE_W-1:0]  v,
                            input logic [LETTER_W-1:0] ltr,
                            input logic                lst);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - LETTER_W - VALUE_W){1'b0}}, ltr, v};
        s_tuser  <= cmd;
        s_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_tready);
        sent_cnt++;
    endtask

    // Letter field is don't-care on loads; drive it random anyway.
    task automatic send_template();
        foreach (tmpl_q[j])
            put_item(CMD_LOAD, tmpl_q[j], LETTER_W'($urandom), j == tmpl_q.size() - 1);
    endtask

    // Value field is don't-care on letters; same idea.
    task automatic send_word();
        foreach (word_q[j])
            put_item(CMD_CHECK, VALUE_W'($urandom), word_q[j], j == word_q.size() - 1);
    endtask

    // Stop sending and let every outstanding verdict drain.
    task automatic wait_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Mixed/broken traffic: loads and letters interleaved with random last marks.
    // Noise starts at position 0 and stays at most eight items, and the long
    // template at the start wrote all low entries, so no unwritten entry is read.
    task automatic send_noise();
        repeat ($urandom_range(2, 8))
            put_item($urandom_range(0, 1) ? CMD_CHECK : CMD_LOAD, VALUE_W'($urandom),
                     LETTER_W'($urandom), $urandom_range(0, 3) == 0);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        return ($urandom_range(0, 2) == 0) ? corner_vals[$urandom_range(0, 3)]
                                           : VALUE_W'($urandom);
    endfunction

    // Build a candidate that pairs one to one with tmpl_q: each distinct value
    // gets its own random letter. Needs at most ALPHABET_SIZE distinct values.
    function automatic void fill_match();
        logic [VALUE_W-1:0]       seen_val [$];
        logic [LETTER_W-1:0]      seen_ltr [$];
        logic [ALPHABET_SIZE-1:0] taken;
        logic [LETTER_W-1:0]      pick;
        int                       hit;
        taken = '0;
        word_q.delete();
        foreach (tmpl_q[j])
        begin
            hit = -1;
            foreach (seen_val[k])
            begin
                if (seen_val[k] == tmpl_q[j])
                    hit = k;
            end
            if (hit < 0)
            begin
                do
                    pick = LETTER_W'($urandom_range(0, ALPHABET_SIZE - 1));
                while (taken[pick]);
                taken[pick] = 1'b1;
                seen_val.push_back(tmpl_q[j]);
                seen_ltr.push_back(pick);
                hit = seen_val.size() - 1;
            end
            word_q.push_back(seen_ltr[hit]);
        end
    endfunction

    initial
    begin
        int         rand_base;
        int         len;
        int         pool_n;
        word_kind_t kind;

        // 26 distinct values, extremes first; odd multiplier keeps the rest distinct
        foreach (alpha_vals[k])
            alpha_vals[k] = (k < 4) ? corner_vals[k] : VALUE_W'(k * 32'h9e37_79b9);

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // ---- directed ----
        // candidate before any template: length 0, must fail
        word_q = '{LTR_A};
        send_word();

        // long template using the whole alphabet. Also leaves the low template
        // entries written, so later mixed traffic is safe.
        tmpl_q.delete();
        for (int j = 0; j < PREFILL_LEN; j++)
            tmpl_q.push_back(alpha_vals[j % ALPHABET_SIZE]);
        send_template();

        // candidate that pairs one to one: passes
        fill_match();
        send_word();
        // same candidate run past the template length: fails
        repeat (4) word_q.push_back(LETTER_W'($urandom_range(0, ALPHABET_SIZE - 1)));
        send_word();

        // template with a repeated value: z a z pairs, z a a does not
        tmpl_q = '{V_MAX, V_MIN, V_MAX};
        send_template();
        word_q = '{LTR_Z, LTR_A, LTR_Z};
        send_word();
        word_q = '{LTR_Z, LTR_A, LTR_A};    // value already owned by another letter
        send_word();
        word_q = '{LTR_Z, LTR_A};           // candidate shorter than template
        send_word();
        word_q = '{LTR_Z, LTR_OUT, LTR_Z};  // letter outside the alphabet
        send_word();

        tmpl_q = '{32'h0, 32'hffff_ffff};
        send_template();
        word_q = '{LTR_B, LTR_B};           // letter already bound to another value
        send_word();

        tmpl_q = '{32'd7};                  // single-element template
        send_template();
        word_q = '{LTR_Y};
        send_word();

        // hold off until every verdict so far has come back
        wait_results();

        // ---- random ----
        // Mostly a template followed by a few candidates built from it, then
        // corrupted in various ways; some noise of interleaved loads and letters.
        rand_base = sent_cnt;
        while (sent_cnt - rand_base < RANDOM_ITEMS)
        begin
            len    = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                                 : $urandom_range(1, 12);
            pool_n = $urandom_range(1, (len < 8) ? len : 8);
            pool_q.delete();
            repeat (pool_n) pool_q.push_back(pick_value());
            tmpl_q.delete();
            repeat (len) tmpl_q.push_back(pool_q[$urandom_range(0, pool_n - 1)]);
            send_template();

            repeat ($urandom_range(1, 6))
            begin
                fill_match();
                len  = $urandom_range(0, 9);
                kind = (len < 5) ? WK_MATCH : word_kind_t'(len - 4);
                case (kind)
                    WK_TYPO:
                        word_q[$urandom_range(0, word_q.size() - 1)] = LETTER_W'($urandom);
                    WK_SHORT:
                        if (word_q.size() > 1)
                            void'(word_q.pop_back());
                        else
                            word_q.push_back(LETTER_W'($urandom));
                    WK_LONG:
                        repeat ($urandom_range(1, 3)) word_q.push_back(LETTER_W'($urandom));
                    WK_SCRAMBLE:
                        foreach (word_q[j])
                            word_q[j] = LETTER_W'($urandom_range(0, ALPHABET_SIZE - 1));
                    WK_NOISE:
                        send_noise();
                    default:
                        ;
                endcase
                send_word();
            end

            if ($urandom_range(0, 7) == 0)
                wait_results();
        end

        // ---- wind down ----
        wait_results();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/tbc_pkg.sv
rtl/template_bijection_checker.sv
dv/template_bijection_checker_chk.sv
dv/template_bijection_checker_tb.sv
